### rtl/cwh_pkg.sv
// Shared types, constants and helpers for the controller word to HID report block.
// No dependencies; compiled first.
`default_nettype none

package cwh_pkg;

	// slot store
	localparam int SLOT_COUNT = 4;
	localparam int SLOT_W     = 2;
	localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [SLOT_W+2:0] SLOT_LIMIT = (SLOT_W + 3)'(SLOT_COUNT);

	// result queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QLW    = QAW + 1;

	// controller type codes (key word bits 31..28)
	localparam logic [3:0] TYPE_DPAD_A = 4'd1;
	localparam logic [3:0] TYPE_DPAD_B = 4'd2;
	localparam logic [3:0] TYPE_APAD   = 4'd3;
	localparam logic [3:0] TYPE_KBD    = 4'd4;
	localparam logic [3:0] TYPE_MOUSE  = 4'd5;
	localparam int         TYPE_LSB    = 28;

	localparam logic [31:0] AXIS_CENTER = 32'h8080_8080;
	localparam logic [3:0]  LEN_FULL    = 4'd8;
	localparam logic [3:0]  LEN_MOUSE   = 4'd6;

	typedef enum logic {
		OP_POLL    = 1'b0,
		OP_REFRESH = 1'b1
	} op_t;

	typedef enum logic {
		EV_REMOUNT = 1'b0,
		EV_REPORT  = 1'b1
	} ev_kind_t;

	typedef enum logic [1:0] {
		DESC_NONE  = 2'd0,
		DESC_PAD   = 2'd1,
		DESC_KBD   = 2'd2,
		DESC_MOUSE = 2'd3
	} desc_t;

	// one RAM word per slot
	typedef struct packed {
		logic [3:0]  stype;
		logic [63:0] report;
		logic [15:0] mcount;
	} entry_t;

	// everything one request produces, queued as a unit
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              rm;
		desc_t             rm_desc;
		logic              rp;
		desc_t             rp_desc;
		logic [63:0]       rep;
		logic [3:0]        rep_len;
	} pair_t;

	typedef struct packed {
		logic [QLW-1:0] level;
	} qstat_t;

	function automatic desc_t desc_of(input logic [3:0] t);
		desc_t d;
		if (t == TYPE_DPAD_A || t == TYPE_DPAD_B || t == TYPE_APAD) begin
			d = DESC_PAD;
		end else if (t == TYPE_KBD) begin
			d = DESC_KBD;
		end else if (t == TYPE_MOUSE) begin
			d = DESC_MOUSE;
		end else begin
			d = DESC_NONE;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

### rtl/cwh_if.sv
// Valid/ready channel interfaces: controller words in, HID events out.
// Stand-alone; widths follow the field list of the block.
`default_nettype none

interface cwh_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [1:0]  slot;
	logic [31:0] key_word;
	logic [31:0] joy_word;
	logic [15:0] trig_word;

	modport source (output valid, opcode, slot, key_word, joy_word, trig_word, input ready);
	modport sink   (input valid, opcode, slot, key_word, joy_word, trig_word, output ready);
endinterface

interface cwh_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_slot;
	logic        event_kind;
	logic [1:0]  descriptor_id;
	logic [63:0] report_bytes;
	logic [3:0]  report_len;
	logic        last_of_run;

	modport source (output valid, out_slot, event_kind, descriptor_id, report_bytes,
		report_len, last_of_run, input ready);
	modport sink   (input valid, out_slot, event_kind, descriptor_id, report_bytes,
		report_len, last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/cwh_ram.sv
// Generic single-write, single-read RAM with registered read (read-old on collision).
// No package dependency.
`default_nettype none

module cwh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

### rtl/cwh_res_queue.sv
// Result queue: one entry per request holding its remount and/or report result,
// unpacked onto the event channel in order. Uses cwh_pkg and cwh_res_if.
`default_nettype none

module cwh_res_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cwh_pkg::pair_t push_data,
	output      cwh_pkg::qstat_t stat,
	cwh_res_if.source           event_ch
);
	import cwh_pkg::*;

	pair_t          arr_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QLW-1:0] level_q;
	logic           sub_q;   // head's remount already delivered
	pair_t          head;
	logic           show_rm;
	logic           last;
	logic           take;
	logic           pop;

	assign head    = arr_q[rd_ptr_q];
	assign show_rm = head.rm && !sub_q;
	assign last    = show_rm ? !head.rp : 1'b1;
	assign take    = event_ch.valid && event_ch.ready;
	assign pop     = take && last;

	assign event_ch.valid         = (level_q != '0);
	assign event_ch.out_slot      = head.slot;
	assign event_ch.event_kind    = show_rm ? EV_REMOUNT : EV_REPORT;
	assign event_ch.descriptor_id = show_rm ? head.rm_desc : head.rp_desc;
	assign event_ch.report_bytes  = show_rm ? 64'd0 : head.rep;
	assign event_ch.report_len    = show_rm ? 4'd0 : head.rep_len;
	assign event_ch.last_of_run   = last;

	assign stat.level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			arr_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + QLW'(1);
			end else if (!push && pop) begin
				level_q <= level_q - QLW'(1);
			end
			if (take) begin
				sub_q <= !last;
			end
		end
	end
endmodule

`default_nettype wire

### rtl/controller_word_to_hid_report_core.sv
// Controller word to HID report converter, top level.
// Uses cwh_pkg, cwh_if (channels), cwh_ram (slot store), cwh_res_queue (results).
//
// Usage:
//   poll_ch  : requests. opcode poll carries one slot's key/joy/trig words; opcode
//              refresh forgets every slot's stored report and mouse count.
//   event_ch : results. A poll yields zero, one or two results (remount first,
//              then report); last_of_run marks the final one. Refresh and
//              out-of-range slots yield none.
// Timing:
//   Path: the request is registered into stage 1 while the slot RAM is read,
//   then compared, packed and pushed into the result queue behind event_ch.
//   Throughput: one request per cycle while poll_ch.ready is high. The slot
//   store is a single-write, single-read RAM; the read-modify-write loop closes
//   through a last-write bypass. A request that makes two results takes two
//   event_ch transfers; the 4-entry result queue pushes back via poll_ch.ready.
// Stalls: when event_ch.ready is low the queue fills and poll_ch.ready drops;
//   nothing is lost or reordered.
// Reset: arst_n clears all control and the per-slot valid flags, so every slot
//   reads as type 0 with no stored report or count; no clearing pass is needed.
`default_nettype none

module controller_word_to_hid_report_core (
	input  wire logic clk,
	input  wire logic arst_n,
	cwh_req_if.sink   poll_ch,
	cwh_res_if.source event_ch
);
	import cwh_pkg::*;

	// ---------------------------------------------------------------
	// Request acceptance; guarantee queue room for this and the one in flight
	// ---------------------------------------------------------------
	qstat_t qstat;
	logic   acc;

	// stage 1: request registered while the slot RAM is read
	logic              v_s1;
	op_t               op_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [31:0]       key_s1;
	logic [31:0]       joy_s1;
	logic [15:0]       trig_s1;

	assign poll_ch.ready = ((qstat.level + QLW'(v_s1)) <= QLW'(QDEPTH - 2));
	assign acc           = poll_ch.valid && poll_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= op_t'(poll_ch.opcode);
			slot_s1 <= poll_ch.slot;
			key_s1  <= poll_ch.key_word;
			joy_s1  <= poll_ch.joy_word;
			trig_s1 <= poll_ch.trig_word;
		end
	end

	// ---------------------------------------------------------------
	// Slot store
	// ---------------------------------------------------------------
	entry_t ram_rdata;
	entry_t wentry;
	logic   ram_we;
	logic [SLOT_AW-1:0] idx;

	assign idx = SLOT_AW'(slot_s1);

	cwh_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx),
		.wdata(wentry),
		.raddr(SLOT_AW'(poll_ch.slot)),
		.rdata(ram_rdata)
	);

	// per-slot flags: entry ever written, stored report live, mouse count live
	logic [SLOT_COUNT-1:0] wr_v_q;
	logic [SLOT_COUNT-1:0] rpt_v_q;
	logic [SLOT_COUNT-1:0] mc_v_q;

	// last write, covers the read that collided with it
	logic               byp_v_q;
	logic [SLOT_AW-1:0] byp_idx_q;
	entry_t             byp_data_q;

	// ---------------------------------------------------------------
	// Compare and pack
	// ---------------------------------------------------------------
	entry_t      ent;
	logic        in_range;
	logic        poll_ok;
	logic [3:0]  t;
	logic [3:0]  old_type;
	logic        chg;
	logic        is_pad;
	logic        is_kbd;
	logic        is_mouse;
	logic [31:0] jx;
	logic [15:0] tg;
	logic [63:0] rep_pk;
	logic        rpt_v_eff;
	logic        mc_v_eff;
	logic        pk_emit;
	logic        ms_emit;
	logic [15:0] cnt;
	logic [15:0] dx;
	logic [15:0] dy;
	logic [63:0] ms_rep;
	logic        push;
	pair_t       pair;

	always_comb begin
		ent      = (byp_v_q && byp_idx_q == idx) ? byp_data_q : ram_rdata;
		in_range = ({3'b000, slot_s1} < SLOT_LIMIT);
		poll_ok  = v_s1 && (op_s1 == OP_POLL) && in_range;
		t        = key_s1[TYPE_LSB +: 4];
		old_type = wr_v_q[idx] ? ent.stype : 4'd0;
		chg      = (t != old_type);

		is_pad   = (t == TYPE_DPAD_A) || (t == TYPE_DPAD_B) || (t == TYPE_APAD);
		is_kbd   = (t == TYPE_KBD);
		is_mouse = (t == TYPE_MOUSE);

		// a remount forgets whatever the slot held
		rpt_v_eff = rpt_v_q[idx] && !chg;
		mc_v_eff  = mc_v_q[idx] && !chg;

		// digital pads report centered axes and released triggers
		jx = (t == TYPE_APAD) ? joy_s1 : AXIS_CENTER;
		tg = (t == TYPE_APAD) ? trig_s1 : 16'd0;
		if (is_kbd) begin
			rep_pk = {trig_s1[7:0], trig_s1[15:8], joy_s1[7:0], joy_s1[15:8],
				joy_s1[23:16], joy_s1[31:24], 8'd0, key_s1[15:8]};
		end else begin
			rep_pk = {tg, jx, key_s1[15:0]};
		end
		pk_emit = (is_pad || is_kbd) && !(rpt_v_eff && ent.report == rep_pk);

		// mouse: count and deltas arrive byte-swapped; first report has no motion
		cnt     = {key_s1[7:0], key_s1[15:8]};
		ms_emit = is_mouse && (!mc_v_eff || cnt != ent.mcount);
		dx      = mc_v_eff ? {joy_s1[7:0], joy_s1[15:8]} : 16'd0;
		dy      = mc_v_eff ? {trig_s1[7:0], trig_s1[15:8]} : 16'd0;
		ms_rep  = {16'd0, dy, dx, 8'd0, joy_s1[23:16]};

		ram_we        = poll_ok;
		wentry.stype  = t;
		wentry.report = pk_emit ? rep_pk : ent.report;
		wentry.mcount = ms_emit ? cnt : ent.mcount;

		push         = poll_ok && (chg || pk_emit || ms_emit);
		pair.slot    = slot_s1;
		pair.rm      = chg;
		pair.rm_desc = desc_of(t);
		pair.rp      = pk_emit || ms_emit;
		pair.rp_desc = desc_of(t);
		pair.rep     = ms_emit ? ms_rep : rep_pk;
		pair.rep_len = ms_emit ? LEN_MOUSE : LEN_FULL;
	end

	// flag and bypass updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q  <= '0;
			rpt_v_q <= '0;
			mc_v_q  <= '0;
			byp_v_q <= 1'b0;
		end else begin
			if (v_s1 && op_s1 == OP_REFRESH) begin
				rpt_v_q <= '0;
				mc_v_q  <= '0;
			end else if (poll_ok) begin
				wr_v_q[idx]  <= 1'b1;
				rpt_v_q[idx] <= pk_emit || rpt_v_eff;
				mc_v_q[idx]  <= ms_emit || mc_v_eff;
			end
			if (poll_ok) begin
				byp_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll_ok) begin
			byp_idx_q  <= idx;
			byp_data_q <= wentry;
		end
	end

	// ---------------------------------------------------------------
	// Result queue
	// ---------------------------------------------------------------
	cwh_res_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(pair),
		.stat     (qstat),
		.event_ch (event_ch)
	);

`ifndef SYNTH
	// the ready rule must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (qstat.level != QLW'(QDEPTH)))
		else $error("result queue overflow");

	// refresh never produces a result
	a_refresh_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && op_s1 == OP_REFRESH) |-> !push)
		else $error("refresh produced a result");

	// an accepted request is worked on in the next cycle
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted request lost");

	// a queued report always carries a length of 6 or 8
	a_report_len: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pair.rp) |-> (pair.rep_len == LEN_FULL || pair.rep_len == LEN_MOUSE))
		else $error("bad report length");
`endif

endmodule

`default_nettype wire

### dv/tb_controller_word_to_hid_report_core.sv
// Testbench for controller_word_to_hid_report_core: a directed table, then random polls
// under three pacing phases. Results are checked against typed rows or the slot model.
// Depends on cwh_pkg, cwh_if and the RTL of the block; self-contained otherwise.
`timescale 1ns / 1ps

module tb_controller_word_to_hid_report_core;
	import cwh_pkg::*;

	// one poll or refresh request as it goes onto poll_ch
	typedef struct packed {
		op_t         op;
		logic [1:0]  slot;
		logic [31:0] key;
		logic [31:0] joy;
		logic [15:0] trig;
	} poll_item_t;

	// one result as it comes off event_ch
	typedef struct packed {
		logic [1:0]  slot;
		ev_kind_t    kind;
		desc_t       desc;
		logic [63:0] rep;
		logic [3:0]  len;
		logic        last;
	} hid_event_t;

	// directed row; n_typed < 0 means the slot model supplies the expectation
	typedef struct {
		poll_item_t item;
		int         n_typed;
		hid_event_t ev0;
		hid_event_t ev1;
	} dir_row_t;

	localparam hid_event_t NO_EV       = '0;
	localparam int         DIR_N       = 25;
	localparam int         RAND_PER_PH = 150;
	localparam int         HOLD_CYCLES = 150;
	localparam int         DRAIN_WAIT  = 8;

	// Directed part. Typed expectations only where the packing is obvious:
	// remount then report, unchanged report suppressed, keyboard byte order,
	// first mouse report with zero deltas, byte-swapped deltas, refresh,
	// types with no descriptor. The rest goes through the slot model.
	dir_row_t dir_tab [DIR_N] = '{
		// type 0 on a fresh slot: no change, nothing out
		'{'{OP_POLL, 2'd0, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 0, NO_EV, NO_EV},
		// digital pad: axes centered, triggers zero
		'{'{OP_POLL, 2'd0, 32'h1000_ABCD, 32'h1234_5678, 16'h9ABC}, 2,
			'{2'd0, EV_REMOUNT, DESC_PAD, 64'h0, 4'd0, 1'b0},
			'{2'd0, EV_REPORT, DESC_PAD, 64'h0000_8080_8080_ABCD, LEN_FULL, 1'b1}},
		'{'{OP_POLL, 2'd0, 32'h1000_ABCD, 32'h1234_5678, 16'h9ABC}, 0, NO_EV, NO_EV},
		// analog pad, all ones then all zeros
		'{'{OP_POLL, 2'd1, 32'h3000_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, 2,
			'{2'd1, EV_REMOUNT, DESC_PAD, 64'h0, 4'd0, 1'b0},
			'{2'd1, EV_REPORT, DESC_PAD, 64'hFFFF_FFFF_FFFF_FFFF, LEN_FULL, 1'b1}},
		'{'{OP_POLL, 2'd1, 32'h3000_0000, 32'h0000_0000, 16'h0000}, 1,
			'{2'd1, EV_REPORT, DESC_PAD, 64'h0, LEN_FULL, 1'b1}, NO_EV},
		// keyboard: modifiers in byte 0, keys big-endian
		'{'{OP_POLL, 2'd2, 32'h4000_AB00, 32'h1122_3344, 16'h5566}, 2,
			'{2'd2, EV_REMOUNT, DESC_KBD, 64'h0, 4'd0, 1'b0},
			'{2'd2, EV_REPORT, DESC_KBD, 64'h6655_4433_2211_00AB, LEN_FULL, 1'b1}},
		// mouse, first report: buttons only
		'{'{OP_POLL, 2'd3, 32'h5000_3412, 32'h0007_FFFF, 16'h1234}, 2,
			'{2'd3, EV_REMOUNT, DESC_MOUSE, 64'h0, 4'd0, 1'b0},
			'{2'd3, EV_REPORT, DESC_MOUSE, 64'h0000_0000_0000_0007, LEN_MOUSE, 1'b1}},
		'{'{OP_POLL, 2'd3, 32'h5000_3412, 32'h0007_FFFF, 16'h1234}, 0, NO_EV, NO_EV},
		// mouse count moves: deltas byte-swapped
		'{'{OP_POLL, 2'd3, 32'h5000_3512, 32'h0005_0201, 16'h0403}, 1,
			'{2'd3, EV_REPORT, DESC_MOUSE, 64'h0000_0304_0102_0005, LEN_MOUSE, 1'b1}, NO_EV},
		'{'{OP_REFRESH, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, 0, NO_EV, NO_EV},
		// after refresh: stored reports and counts forgotten
		'{'{OP_POLL, 2'd0, 32'h1000_ABCD, 32'h1234_5678, 16'h9ABC}, -1, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd3, 32'h5000_3512, 32'h0005_0201, 16'h0403}, -1, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd1, 32'h3000_0000, 32'h0000_0000, 16'h0000}, -1, NO_EV, NO_EV},
		// types with no descriptor: remount to none, no report
		'{'{OP_POLL, 2'd2, 32'h6000_0000, 32'h0000_0000, 16'h0000}, 1,
			'{2'd2, EV_REMOUNT, DESC_NONE, 64'h0, 4'd0, 1'b1}, NO_EV},
		'{'{OP_POLL, 2'd2, 32'hF000_0000, 32'h0000_0000, 16'h0000}, 1,
			'{2'd2, EV_REMOUNT, DESC_NONE, 64'h0, 4'd0, 1'b1}, NO_EV},
		'{'{OP_POLL, 2'd2, 32'h0000_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1,
			'{2'd2, EV_REMOUNT, DESC_NONE, 64'h0, 4'd0, 1'b1}, NO_EV},
		'{'{OP_POLL, 2'd0, 32'h2FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, -1, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd2, 32'h4FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, -1, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd2, 32'h4FFF_FFFF, 32'h0000_0000, 16'h0000}, -1, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd1, 32'h5FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, -1, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd1, 32'h5FFF_FEFF, 32'h8000_8000, 16'h8001}, -1, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd1, 32'h5FFF_FEFF, 32'h0000_0000, 16'h0000}, -1, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd0, 32'h5000_0000, 32'h0000_0000, 16'h0000}, -1, NO_EV, NO_EV},
		'{'{OP_REFRESH, 2'd0, 32'h0000_0000, 32'h0000_0000, 16'h0000}, 0, NO_EV, NO_EV},
		'{'{OP_POLL, 2'd3, 32'h0000_0000, 32'h0000_0000, 16'h0000}, -1, NO_EV, NO_EV}
	};

	logic clk = 1'b0;
	logic arst_n;

	cwh_req_if poll_ch ();
	cwh_res_if event_ch ();

	controller_word_to_hid_report_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.poll_ch  (poll_ch),
		.event_ch (event_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// slot model state
	logic [3:0]  mdl_type   [SLOT_COUNT];
	logic [63:0] mdl_rep    [SLOT_COUNT];
	logic [3:0]  mdl_len    [SLOT_COUNT];
	logic [15:0] mdl_cnt    [SLOT_COUNT];
	bit          mdl_cnt_ok [SLOT_COUNT];

	hid_event_t model_events [$];   // what the last request made
	hid_event_t pending_events [$]; // expected on event_ch, oldest first

	// last poll accepted per slot, used to build repeats
	poll_item_t last_poll [SLOT_COUNT];
	bit         seen_poll [SLOT_COUNT];

	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_request;

	int err_count;
	int reqs_sent;
	int refreshes_sent;
	int events_seen;
	int remounts_seen;
	int mouse_reports_seen;

	// Slot model: one accepted request in, its results into model_events.
	function automatic void hid_model_step(input poll_item_t it);
		logic [1:0]  s;
		logic [3:0]  t;
		desc_t       d;
		logic [63:0] rep;
		logic [31:0] joy;
		logic [15:0] trig;
		logic [15:0] cnt;
		logic [15:0] dx;
		logic [15:0] dy;
		bit          full;
		bit          first;
		model_events.delete();
		s    = it.slot;
		rep  = '0;
		full = 1'b0;
		if (it.op == OP_REFRESH) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				mdl_len[i]    = '0;
				mdl_cnt_ok[i] = 1'b0;
			end
			return;
		end
		// only reachable when the slot field can name more slots than exist
		if (int'(s) >= SLOT_COUNT) begin
			return;
		end
		t = it.key[31:TYPE_LSB];
		case (t)
			TYPE_DPAD_A, TYPE_DPAD_B, TYPE_APAD: d = DESC_PAD;
			TYPE_KBD:                            d = DESC_KBD;
			TYPE_MOUSE:                          d = DESC_MOUSE;
			default:                             d = DESC_NONE;
		endcase
		if (t != mdl_type[s]) begin
			mdl_type[s]   = t;
			mdl_rep[s]    = '0;
			mdl_len[s]    = '0;
			mdl_cnt[s]    = '0;
			mdl_cnt_ok[s] = 1'b0;
			model_events.push_back('{s, EV_REMOUNT, d, 64'h0, 4'd0, 1'b0});
		end
		case (t)
			TYPE_DPAD_A, TYPE_DPAD_B, TYPE_APAD: begin
				joy  = (t == TYPE_APAD) ? it.joy : AXIS_CENTER;
				trig = (t == TYPE_APAD) ? it.trig : 16'h0;
				rep  = {trig, joy, it.key[15:0]};
				full = 1'b1;
			end
			TYPE_KBD: begin
				rep  = {it.trig[7:0], it.trig[15:8], it.joy[7:0], it.joy[15:8],
					it.joy[23:16], it.joy[31:24], 8'h00, it.key[15:8]};
				full = 1'b1;
			end
			TYPE_MOUSE: begin
				cnt = {it.key[7:0], it.key[15:8]};
				if (!mdl_cnt_ok[s] || cnt != mdl_cnt[s]) begin
					first         = !mdl_cnt_ok[s];
					mdl_cnt[s]    = cnt;
					mdl_cnt_ok[s] = 1'b1;
					dx  = first ? 16'h0 : {it.joy[7:0], it.joy[15:8]};
					dy  = first ? 16'h0 : {it.trig[7:0], it.trig[15:8]};
					rep = {16'h0, dy, dx, 8'h00, it.joy[23:16]};
					model_events.push_back('{s, EV_REPORT, DESC_MOUSE, rep, LEN_MOUSE, 1'b0});
				end
			end
			default: ;
		endcase
		// pad and keyboard reports go out only when they differ from the stored one
		if (full && !(mdl_len[s] == LEN_FULL && mdl_rep[s] == rep)) begin
			mdl_rep[s] = rep;
			mdl_len[s] = LEN_FULL;
			model_events.push_back('{s, EV_REPORT, d, rep, LEN_FULL, 1'b0});
		end
		if (model_events.size() > 0) begin
			model_events[model_events.size() - 1].last = 1'b1;
		end
	endfunction

	// Random request. Mostly polls that keep a slot's type so reports are
	// compared against stored ones; some exact or partial repeats so the
	// suppression paths are hit; a few refreshes and arbitrary type nibbles.
	function automatic poll_item_t make_poll();
		poll_item_t it;
		poll_item_t prev;
		int         pick;
		logic [3:0] kind;
		pick      = $urandom_range(0, 99);
		it.op     = OP_POLL;
		it.slot   = 2'($urandom_range(0, SLOT_COUNT - 1));
		it.key    = $urandom;
		it.joy    = $urandom;
		it.trig   = 16'($urandom);
		prev      = last_poll[it.slot];
		if (pick < 5) begin
			it.op = OP_REFRESH;
		end else if (pick < 35 && seen_poll[it.slot]) begin
			case ($urandom_range(0, 2))
				0: it = prev;
				1: it.key = prev.key;                 // same count / buttons, new axes
				default: begin                        // same type and axes, new low key
					it.joy           = prev.joy;
					it.trig          = prev.trig;
					it.key[31:16]    = prev.key[31:16];
				end
			endcase
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				kind = mdl_type[it.slot];
			end else if (pick < 88) begin
				kind = 4'($urandom_range(TYPE_DPAD_A, TYPE_MOUSE));
			end else begin
				kind = 4'($urandom_range(0, 15));
			end
			it.key[31:TYPE_LSB] = kind;
		end
		return it;
	endfunction

	// Offer one request; on acceptance queue what it should produce.
	task automatic offer(input poll_item_t it, input int n_typed,
			input hid_event_t t0, input hid_event_t t1);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			poll_ch.valid <= 1'b0;
			@(posedge clk);
		end
		poll_ch.valid     <= 1'b1;
		poll_ch.opcode    <= it.op;
		poll_ch.slot      <= it.slot;
		poll_ch.key_word  <= it.key;
		poll_ch.joy_word  <= it.joy;
		poll_ch.trig_word <= it.trig;
		do @(posedge clk); while (!poll_ch.ready);
		hid_model_step(it);
		if (n_typed < 0) begin
			foreach (model_events[i]) pending_events.push_back(model_events[i]);
		end else begin
			if (n_typed > 0) pending_events.push_back(t0);
			if (n_typed > 1) pending_events.push_back(t1);
		end
		reqs_sent++;
		if (it.op == OP_REFRESH) begin
			refreshes_sent++;
		end else begin
			last_poll[it.slot] = it;
			seen_poll[it.slot] = 1'b1;
		end
	endtask

	// Sender stops and waits for every outstanding result.
	task automatic drain();
		poll_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// Receiver: random or held-off ready, check every accepted result.
	initial begin
		hid_event_t want;
		int         hold_left;
		hold_left      = 0;
		event_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && event_ch.valid && event_ch.ready) begin
				if (pending_events.size() == 0) begin
					err_count++;
					$display("%0t ns: unexpected result, expected none, got slot %0d kind %0d",
						$time, event_ch.out_slot, event_ch.event_kind);
				end else begin
					want = pending_events.pop_front();
					events_seen++;
					if (want.kind == EV_REMOUNT) remounts_seen++;
					if (want.kind == EV_REPORT && want.len == LEN_MOUSE) mouse_reports_seen++;
					check_field("out_slot", want.slot, event_ch.out_slot);
					check_field("event_kind", want.kind, event_ch.event_kind);
					check_field("descriptor_id", want.desc, event_ch.descriptor_id);
					check_field("report_bytes", want.rep, event_ch.report_bytes);
					check_field("report_len", want.len, event_ch.report_len);
					check_field("last_of_run", want.last, event_ch.last_of_run);
				end
			end
			// a long hold-off lets the result queue fill and back up into poll_ch
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				event_ch.ready <= 1'b0;
			end else begin
				event_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int ph;
		int k;
		err_count          = 0;
		reqs_sent          = 0;
		refreshes_sent     = 0;
		events_seen        = 0;
		remounts_seen      = 0;
		mouse_reports_seen = 0;
		hold_request       = 1'b0;
		tx_idle_pct        = 36;
		rx_idle_pct        = 81;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			mdl_type[i]   = '0;
			mdl_rep[i]    = '0;
			mdl_len[i]    = '0;
			mdl_cnt[i]    = '0;
			mdl_cnt_ok[i] = 1'b0;
			seen_poll[i]  = 1'b0;
			last_poll[i]  = '0;
		end
		arst_n            <= 1'b0;
		poll_ch.valid     <= 1'b0;
		poll_ch.opcode    <= OP_POLL;
		poll_ch.slot      <= '0;
		poll_ch.key_word  <= '0;
		poll_ch.joy_word  <= '0;
		poll_ch.trig_word <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the first pacing
		for (k = 0; k < DIR_N; k++) begin
			offer(dir_tab[k].item, dir_tab[k].n_typed, dir_tab[k].ev0, dir_tab[k].ev1);
		end
		drain();

		// random phases: slow receiver, then slow sender, then full rate;
		// the full-rate phase opens with a long receiver hold-off
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 36;
					rx_idle_pct = 81;
				end
				1: begin
					tx_idle_pct = 81;
					rx_idle_pct = 36;
				end
				default: begin
					tx_idle_pct  = 0;
					rx_idle_pct  = 0;
					hold_request = 1'b1;
				end
			endcase
			for (k = 0; k < RAND_PER_PH; k++) begin
				offer(make_poll(), -1, NO_EV, NO_EV);
			end
			drain();
		end

		// trailing window catches anything extra the block still emits
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("run covered %0d requests (%0d refresh) and %0d results", reqs_sent,
			refreshes_sent, events_seen);
		$display("  %0d remounts, %0d mouse reports, three pacing phases, one long hold-off",
			remounts_seen, mouse_reports_seen);
		if (err_count == 0) begin
			$display("tb_controller_word_to_hid_report_core: clean");
		end else begin
			$display("tb_controller_word_to_hid_report_core: errors");
		end
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("tb_controller_word_to_hid_report_core: errors");
		$finish;
	end

endmodule

### filelist.f
rtl/cwh_pkg.sv
rtl/cwh_if.sv
rtl/cwh_ram.sv
rtl/cwh_res_queue.sv
rtl/controller_word_to_hid_report_core.sv
dv/tb_controller_word_to_hid_report_core.sv
